[src/assert_macros.svh]
// Assertion helpers used by the back stage of the arc slip tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CAST_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// A condition that implies a consequence in the same cycle.
`define CAST_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// A condition that implies a consequence in the next cycle.
`define CAST_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/cast_pkg.sv]
package cast_pkg;

    // Default table geometry and queue depth.
    localparam int SAT_SLOTS_DEF = 64;
    localparam int SIG_SLOTS_DEF = 4;
    localparam int QUEUE_DEPTH   = 2;

    // Port widths.
    localparam int TDATA_IN_W  = 176;
    localparam int TUSER_IN_W  = 3;
    localparam int TDATA_OUT_W = 40;
    localparam int TUSER_OUT_W = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 22;

    // Milliseconds in one GNSS week.
    localparam logic [29:0] WEEK_MS = 30'd604800000;

    // Register reset values.
    localparam logic [21:0] LOCK_TOL_RST    = 22'd100;
    localparam logic [21:0] ROVER_GAP_RST   = 22'd1000;
    localparam logic [21:0] BASE_GAP_RST    = 22'd5000;
    localparam logic [20:0] PHASE_LIM_RST   = 21'd5120;

    typedef enum logic [1:0] {
        CFG_LOCK_TOL  = 2'd0,
        CFG_ROVER_GAP = 2'd1,
        CFG_BASE_GAP  = 2'd2,
        CFG_PHASE_LIM = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CAUSE_NONE     = 3'd0,
        CAUSE_FIRST    = 3'd1,
        CAUSE_REACQ    = 3'd2,
        CAUSE_LOCK     = 3'd3,
        CAUSE_CHANNEL  = 3'd4,
        CAUSE_GAP      = 3'd5,
        CAUSE_DOPPLER  = 3'd6,
        CAUSE_REVERSAL = 3'd7
    } cause_t;

    typedef enum logic [1:0] {
        KIND_SKIP    = 2'd0,
        KIND_INVALID = 2'd1,
        KIND_CHECK   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_DIFF   = 3'd2,
        ST_DELTA  = 3'd3,
        ST_PROD   = 3'd4,
        ST_ERR    = 3'd5,
        ST_FINISH = 3'd6
    } back_state_t;

    typedef struct packed {
        kind_t        kind;
        logic         from_base;
        logic [5:0]   sat;
        logic [1:0]   sig;
        logic [15:0]  week;
        logic [29:0]  tow;
        logic [47:0]  phase;
        logic [31:0]  doppler;
        logic         doppler_ok;
        logic [31:0]  lock;
        logic [7:0]   channel;
    } item_t;

    typedef struct packed {
        logic         active;
        logic [31:0]  arc_id;
        logic [15:0]  week;
        logic [29:0]  tow;
        logic [47:0]  phase;
        logic [31:0]  doppler;
        logic         doppler_ok;
        logic [31:0]  lock;
        logic [7:0]   channel;
    } entry_t;

    typedef struct packed {
        logic         usable;
        logic         new_arc;
        logic [31:0]  arc_number;
        cause_t       reset_cause;
    } result_t;

    typedef struct packed {
        logic [21:0]  lock_tol;
        logic [21:0]  rover_gap;
        logic [21:0]  base_gap;
        logic [20:0]  phase_lim;
    } cfg_t;

endpackage

[src/carrier_arc_slip_tracker.sv]
// Carrier-phase arc slip tracker. Each observation is checked against the stored arc
// state of its receiver, satellite slot and signal slot; the first reset cause found
// starts a new arc with an id from a counter that starts at 1 and skips 0. A front
// stage takes and classifies transactions into a two-entry queue, and a back stage
// performs one table read, four check steps and one write-back per in-range item,
// and takes the next item only once the last result is loaded, as it runs that
// read-check-write sequence on the single table memory. After reset the table's
// 2*SATELLITE_SLOTS*SIGNAL_SLOTS entries (512 by default) are cleared one entry a
// cycle, during which s_tready stays low; configuration writes are taken at any time.
module carrier_arc_slip_tracker #(
    parameter int SATELLITE_SLOTS = cast_pkg::SAT_SLOTS_DEF,
    parameter int SIGNAL_SLOTS    = cast_pkg::SIG_SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [cast_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [cast_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // satellite_slot, signal_slot, gnss_week, tow_ms, carrier_phase, doppler,
    // lock_ms, channel, zero fill
    input  logic [cast_pkg::TDATA_IN_W-1:0]  s_tdata,
    // from_base, fields_ok, doppler_ok
    input  logic [cast_pkg::TUSER_IN_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // arc_number, reset_cause, zero fill
    output logic [cast_pkg::TDATA_OUT_W-1:0] m_tdata,
    // usable, new_arc
    output logic [cast_pkg::TUSER_OUT_W-1:0] m_tuser
);

    cast_pkg::cfg_t    cfg_reg;
    cast_pkg::item_t   push_item, pop_item;
    cast_pkg::result_t result;
    logic              q_push, q_pop, q_full, q_empty, clearing;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lock_tol  <= cast_pkg::LOCK_TOL_RST;
            cfg_reg.rover_gap <= cast_pkg::ROVER_GAP_RST;
            cfg_reg.base_gap  <= cast_pkg::BASE_GAP_RST;
            cfg_reg.phase_lim <= cast_pkg::PHASE_LIM_RST;
        end else if (cfg_we) begin
            unique case (cast_pkg::cfg_reg_t'(cfg_addr))
                cast_pkg::CFG_LOCK_TOL:  cfg_reg.lock_tol  <= cfg_wdata;
                cast_pkg::CFG_ROVER_GAP: cfg_reg.rover_gap <= cfg_wdata;
                cast_pkg::CFG_BASE_GAP:  cfg_reg.base_gap  <= cfg_wdata;
                cast_pkg::CFG_PHASE_LIM: cfg_reg.phase_lim <= cfg_wdata[20:0];
                default: begin
                end
            endcase
        end
    end

    cast_front #(
        .SATELLITE_SLOTS (SATELLITE_SLOTS),
        .SIGNAL_SLOTS    (SIGNAL_SLOTS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .enable   (!clearing),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    cast_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    cast_back #(
        .SATELLITE_SLOTS (SATELLITE_SLOTS),
        .SIGNAL_SLOTS    (SIGNAL_SLOTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = {5'd0, result.reset_cause, result.arc_number};
    assign m_tuser = {result.new_arc, result.usable};

endmodule

[src/cast_ram.sv]
module cast_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/cast_queue.sv]
module cast_queue #(
    parameter int DEPTH = cast_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  cast_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output cast_pkg::item_t pop_item,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cast_pkg::item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[src/cast_front.sv]
module cast_front #(
    parameter int SATELLITE_SLOTS = cast_pkg::SAT_SLOTS_DEF,
    parameter int SIGNAL_SLOTS    = cast_pkg::SIG_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            enable,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cast_pkg::TDATA_IN_W-1:0] s_tdata,
    input  logic [cast_pkg::TUSER_IN_W-1:0] s_tuser,
    input  logic                            q_full,
    output logic                            q_push,
    output cast_pkg::item_t                 q_item
);

    logic            hold_valid_reg, hold_valid_next;
    cast_pkg::item_t hold_item_reg;
    cast_pkg::item_t in_item;
    logic            accept;
    logic            fields_ok;

    assign q_push   = hold_valid_reg && !q_full;
    assign s_tready = enable && (!hold_valid_reg || !q_full);
    assign accept   = s_tvalid && s_tready;
    assign q_item   = hold_item_reg;

    // Unpack the transaction and classify it.
    always_comb begin
        in_item.from_base  = s_tuser[0];
        fields_ok          = s_tuser[1];
        in_item.doppler_ok = s_tuser[2];
        in_item.sat        = s_tdata[5:0];
        in_item.sig        = s_tdata[7:6];
        in_item.week       = s_tdata[23:8];
        in_item.tow        = s_tdata[53:24];
        in_item.phase      = s_tdata[101:54];
        in_item.doppler    = s_tdata[133:102];
        in_item.lock       = s_tdata[165:134];
        in_item.channel    = s_tdata[173:166];
        if ((32'(in_item.sat) >= 32'(SATELLITE_SLOTS)) ||
            (32'(in_item.sig) >= 32'(SIGNAL_SLOTS))) begin
            in_item.kind = cast_pkg::KIND_SKIP;
        end else if (!fields_ok || (in_item.tow >= cast_pkg::WEEK_MS)) begin
            in_item.kind = cast_pkg::KIND_INVALID;
        end else begin
            in_item.kind = cast_pkg::KIND_CHECK;
        end
    end

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (accept) begin
            hold_valid_next = 1'b1;
        end else if (q_push) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_item_reg <= in_item;
        end
    end

endmodule

[src/cast_back.sv]
`include "assert_macros.svh"

module cast_back #(
    parameter int SATELLITE_SLOTS = cast_pkg::SAT_SLOTS_DEF,
    parameter int SIGNAL_SLOTS    = cast_pkg::SIG_SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cast_pkg::cfg_t    cfg,
    input  logic              q_empty,
    input  cast_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              clearing,
    output logic              m_valid,
    input  logic              m_ready,
    output cast_pkg::result_t m_result
);

    localparam int ENTRIES = 2 * SATELLITE_SLOTS * SIGNAL_SLOTS;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int ENTRY_W = $bits(cast_pkg::entry_t);

    cast_pkg::back_state_t state_reg, state_next;

    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [31:0]       idx_wide;
    cast_pkg::item_t   item_reg;
    logic [31:0]       next_arc_reg, next_arc_next;
    logic              m_valid_reg, m_valid_next;
    cast_pkg::result_t m_result_reg;

    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    cast_pkg::entry_t   rd;
    cast_pkg::entry_t   wr_entry;

    logic out_free, out_load;

    // Datapath terms of the slip checks.
    logic signed [16:0] wk_diff;
    logic signed [47:0] week_prod;
    logic signed [30:0] tow_diff;
    logic signed [48:0] dphi;
    logic signed [32:0] dsum;
    logic               lock_drop;
    logic signed [47:0] delta;
    logic [21:0]        gap_lim;
    logic signed [56:0] prod;
    logic signed [59:0] dphi2k;
    logic signed [60:0] err;
    logic [60:0]        err_mag;
    logic [31:0]        lim2k;

    logic signed [47:0] week_prod_reg;
    logic signed [30:0] tow_diff_reg;
    logic signed [48:0] dphi_reg;
    logic signed [32:0] dsum_reg;
    logic               lock_drop_reg;
    logic               chan_diff_reg;
    logic signed [47:0] delta_reg;
    logic               rev_reg;
    logic               gap_reg;
    logic signed [56:0] prod_reg;
    logic signed [59:0] dphi2k_reg;
    logic               dop_bad_reg;

    cast_pkg::cause_t  cause;
    cast_pkg::result_t res;

    // Entry table: one packed word of arc state per entry.
    cast_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_wide[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd       = cast_pkg::entry_t'(ram_rdata);
    assign out_free = !m_valid_reg || m_ready;
    assign clearing = (state_reg == cast_pkg::ST_CLEAR);
    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    // Entry index of the item at the head of the queue.
    assign idx_wide = 32'(q_item.from_base) * 32'(SATELLITE_SLOTS * SIGNAL_SLOTS)
                    + 32'(q_item.sat) * 32'(SIGNAL_SLOTS) + 32'(q_item.sig);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cast_pkg::ST_CLEAR: begin
                if (clr_reg == IDX_W'(ENTRIES - 1)) begin
                    state_next = cast_pkg::ST_IDLE;
                end
            end
            cast_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    state_next = (q_item.kind == cast_pkg::KIND_SKIP) ?
                                 cast_pkg::ST_FINISH : cast_pkg::ST_DIFF;
                end
            end
            cast_pkg::ST_DIFF:  state_next = cast_pkg::ST_DELTA;
            cast_pkg::ST_DELTA: state_next = cast_pkg::ST_PROD;
            cast_pkg::ST_PROD:  state_next = cast_pkg::ST_ERR;
            cast_pkg::ST_ERR:   state_next = cast_pkg::ST_FINISH;
            cast_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = cast_pkg::ST_IDLE;
                end
            end
            default: state_next = cast_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        q_pop     = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = ENTRY_W'(wr_entry);
        out_load  = 1'b0;
        clr_next  = clr_reg;
        unique case (state_reg)
            cast_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            cast_pkg::ST_IDLE: begin
                q_pop  = !q_empty;
                ram_re = !q_empty;
            end
            cast_pkg::ST_FINISH: begin
                out_load = out_free;
                ram_we   = out_free && (item_reg.kind != cast_pkg::KIND_SKIP);
            end
            default: begin
            end
        endcase
    end

    // First stage: differences against the stored entry.
    always_comb begin
        wk_diff   = $signed({1'b0, item_reg.week}) - $signed({1'b0, rd.week});
        week_prod = wk_diff * $signed({1'b0, cast_pkg::WEEK_MS});
        tow_diff  = $signed({1'b0, item_reg.tow}) - $signed({1'b0, rd.tow});
        dphi      = $signed({item_reg.phase[47], item_reg.phase})
                  - $signed({rd.phase[47], rd.phase});
        dsum      = $signed({item_reg.doppler[31], item_reg.doppler})
                  + $signed({rd.doppler[31], rd.doppler});
        lock_drop = ({1'b0, item_reg.lock} + 33'(cfg.lock_tol)) < {1'b0, rd.lock};
    end

    // Later stages: elapsed time, Doppler prediction product and its error.
    always_comb begin
        delta   = week_prod_reg + 48'(tow_diff_reg);
        gap_lim = item_reg.from_base ? cfg.base_gap : cfg.rover_gap;
        // Only used when the gap check passed, so elapsed time fits 23 bits.
        prod    = dsum_reg * $signed({1'b0, delta_reg[22:0]});
        dphi2k  = (60'(dphi_reg) <<< 11) - (60'(dphi_reg) <<< 5) - (60'(dphi_reg) <<< 4);
        err     = 61'(dphi2k_reg) + 61'(prod_reg);
        err_mag = err[60] ? 61'(-err) : 61'(err);
        lim2k   = ({11'd0, cfg.phase_lim} << 11) - ({11'd0, cfg.phase_lim} << 5)
                - ({11'd0, cfg.phase_lim} << 4);
    end

    always_ff @(posedge aclk) begin
        if (state_reg == cast_pkg::ST_DIFF) begin
            week_prod_reg <= week_prod;
            tow_diff_reg  <= tow_diff;
            dphi_reg      <= dphi;
            dsum_reg      <= dsum;
            lock_drop_reg <= lock_drop;
            chan_diff_reg <= (item_reg.channel != rd.channel);
        end
        if (state_reg == cast_pkg::ST_DELTA) begin
            delta_reg <= delta;
        end
        if (state_reg == cast_pkg::ST_PROD) begin
            rev_reg    <= delta_reg[47] || (delta_reg == '0);
            gap_reg    <= !delta_reg[47] && (delta_reg[46:0] > 47'(gap_lim));
            prod_reg   <= prod;
            dphi2k_reg <= dphi2k;
        end
        if (state_reg == cast_pkg::ST_ERR) begin
            dop_bad_reg <= (err_mag > 61'(lim2k));
        end
        if (q_pop) begin
            item_reg <= q_item;
            idx_reg  <= idx_wide[IDX_W-1:0];
        end
    end

    // Reset cause in order of priority.
    always_comb begin
        cause = cast_pkg::CAUSE_NONE;
        if (item_reg.kind == cast_pkg::KIND_CHECK) begin
            priority if (rd.arc_id == '0) begin
                cause = cast_pkg::CAUSE_FIRST;
            end else if (!rd.active) begin
                cause = cast_pkg::CAUSE_REACQ;
            end else if (rev_reg) begin
                cause = cast_pkg::CAUSE_REVERSAL;
            end else if (gap_reg) begin
                cause = cast_pkg::CAUSE_GAP;
            end else if (lock_drop_reg) begin
                cause = cast_pkg::CAUSE_LOCK;
            end else if (chan_diff_reg) begin
                cause = cast_pkg::CAUSE_CHANNEL;
            end else if (item_reg.doppler_ok && rd.doppler_ok && dop_bad_reg) begin
                cause = cast_pkg::CAUSE_DOPPLER;
            end else begin
                cause = cast_pkg::CAUSE_NONE;
            end
        end
    end

    // Result, entry write-back and arc counter.
    always_comb begin
        res           = '0;
        wr_entry      = rd;
        next_arc_next = next_arc_reg;
        if (item_reg.kind == cast_pkg::KIND_CHECK) begin
            res.usable      = 1'b1;
            res.new_arc     = (cause != cast_pkg::CAUSE_NONE);
            res.reset_cause = cause;
            res.arc_number  = res.new_arc ? next_arc_reg : rd.arc_id;
            wr_entry.active     = 1'b1;
            wr_entry.arc_id     = res.arc_number;
            wr_entry.week       = item_reg.week;
            wr_entry.tow        = item_reg.tow;
            wr_entry.phase      = item_reg.phase;
            wr_entry.doppler    = item_reg.doppler;
            wr_entry.doppler_ok = item_reg.doppler_ok;
            wr_entry.lock       = item_reg.lock;
            wr_entry.channel    = item_reg.channel;
            if (out_load && res.new_arc) begin
                next_arc_next = (next_arc_reg == '1) ? 32'd1 : next_arc_reg + 1'b1;
            end
        end else begin
            wr_entry.active = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cast_pkg::ST_CLEAR;
            clr_reg      <= '0;
            next_arc_reg <= 32'd1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            next_arc_reg <= next_arc_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_result_reg <= res;
        end
    end

    `CAST_ASSERT(a_arc_counter_nonzero, aclk, aresetn, next_arc_reg != '0)
    `CAST_ASSERT_IMPL(a_write_phase, aclk, aresetn, ram_we, (state_reg == cast_pkg::ST_CLEAR || state_reg == cast_pkg::ST_FINISH))
    `CAST_ASSERT_IMPL(a_no_pop_in_clear, aclk, aresetn, clearing, !q_pop)
    `CAST_ASSERT_IMPL(a_unusable_zero, aclk, aresetn, (m_valid_reg && !m_result_reg.usable), (m_result_reg.arc_number == '0 && !m_result_reg.new_arc))
    `CAST_ASSERT_NEXT(a_counter_advance, aclk, aresetn, (out_load && res.new_arc), (next_arc_reg != $past(next_arc_reg)))

endmodule
